FILE: src/rtin_pkg.sv
package rtin_pkg;

  localparam int unsigned IDX_W = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned VERT_DIM_W = 7;
  localparam int unsigned MAX_LEVEL_W = 4;

  localparam logic [VERT_DIM_W-1:0] VERT_DIM_RST = 7'd65;
  localparam logic [MAX_LEVEL_W-1:0] MAX_LEVEL_RST = 4'd12;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VERT_DIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POP,
    ST_EVAL,
    ST_CHECK,
    ST_EMIT
  } st_e;

endpackage

FILE: src/rtin_mesh_triangle_walker_core.sv
// Write word: no result. Fetch word: the walk runs POP (skipped when a new walk starts),
// then EVAL and CHECK once per split, and EMIT loads the result register; the descent ends
// in CHECK on an unmarked midpoint or in EVAL at the level limit, after at most max_level
// splits; each split costs one mark-memory read and one check of the registered mark bit.
// One word is in work at a time; a finished triangle waits in the output register.
// After reset the mark memory is cleared one entry per cycle, all MAX_GRID_DIM*MAX_GRID_DIM
// entries (4225 by default), before the first word is taken; configuration is taken at once.
module rtin_mesh_triangle_walker_core import rtin_pkg::*; #(
  parameter int unsigned MAX_GRID_DIM = 65,
  parameter int unsigned MAX_DEPTH = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [12:0] vertex_index, [13] mark_value, [15:14] zero
  input  logic [15:0]           s_axis_tdata,
  // [0] cmd
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [12:0] vertex_a, [25:13] vertex_b, [38:26] vertex_c, [39] zero
  output logic [39:0]           m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned STORE = MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int unsigned VW = $clog2(STORE);
  localparam int unsigned DW = $clog2(MAX_GRID_DIM + 1);
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned STACK = MAX_DEPTH + 2;
  localparam int unsigned SAW = $clog2(STACK);
  localparam int unsigned SDW = $clog2(STACK + 1);
  localparam int unsigned EW = 3 * VW + LW;

  st_e state_q, state_d;

  logic [VERT_DIM_W-1:0]  vert_dim_q;
  logic [MAX_LEVEL_W-1:0] max_level_q;
  logic                   walk_q, walk_d;
  logic [SDW-1:0]         depth_q, depth_d;
  logic [VW-1:0]          a_q, a_d, b_q, b_d, c_q, c_d;
  logic [LW-1:0]          lvl_q, lvl_d;
  logic [VW-1:0]          clr_q;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_a_q, out_b_q, out_c_q;
  logic                   out_last_q;

  logic                   mark_mem [STORE];
  logic                   mark_rd_q;
  logic                   mark_we;
  logic [VW-1:0]          mark_waddr;
  logic                   mark_wdata;

  logic [EW-1:0]          stk_mem [STACK];
  logic [EW-1:0]          stk_rd_q;
  logic                   stk_we;
  logic [SAW-1:0]         stk_waddr;
  logic [SAW-1:0]         stk_raddr;
  logic [EW-1:0]          stk_wdata;

  logic                   in_acc;
  logic                   cfg_acc;
  logic                   in_cmd;
  logic [IDX_W-1:0]       in_index;
  logic                   in_mark;
  logic                   start_walk;
  logic                   out_load;
  logic [DW-1:0]          gdim;
  logic [SQW-1:0]         gsq;
  logic [LW-1:0]          lim;
  logic [VW:0]            mid_sum;
  logic [VW-1:0]          mid;

  assign in_cmd   = s_axis_tuser[0];
  assign in_index = s_axis_tdata[IDX_W-1:0];
  assign in_mark  = s_axis_tdata[IDX_W];

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_acc      = s_axis_tvalid & s_axis_tready;
  assign start_walk  = !walk_q || (depth_q == '0);

  always_comb begin
    if (vert_dim_q < VERT_DIM_W'(2)) begin
      gdim = DW'(2);
    end else if (32'(vert_dim_q) > MAX_GRID_DIM) begin
      gdim = DW'(MAX_GRID_DIM);
    end else begin
      gdim = DW'(vert_dim_q);
    end
  end

  assign gsq = SQW'(gdim) * SQW'(gdim);
  assign lim = (32'(max_level_q) > MAX_DEPTH) ? LW'(MAX_DEPTH) : LW'(max_level_q);

  assign mid_sum = {1'b0, b_q} + {1'b0, c_q};
  assign mid     = mid_sum[VW:1];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == VW'(STORE - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_FETCH) state_d = start_walk ? ST_EVAL : ST_POP;
      end
      ST_POP:   state_d = ST_EVAL;
      ST_EVAL:  state_d = (lvl_q >= lim) ? ST_EMIT : ST_CHECK;
      ST_CHECK: state_d = mark_rd_q ? ST_EVAL : ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    s_axis_tready = 1'b0;
    a_d           = a_q;
    b_d           = b_q;
    c_d           = c_q;
    lvl_d         = lvl_q;
    depth_d       = depth_q;
    walk_d        = walk_q;
    mark_we       = 1'b0;
    mark_waddr    = clr_q;
    mark_wdata    = 1'b0;
    stk_we        = 1'b0;
    stk_waddr     = SAW'(depth_q);
    stk_raddr     = SAW'(depth_q - SDW'(1));
    stk_wdata     = {mid, c_q, a_q, lvl_q + LW'(1)};
    out_load      = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mark_we = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_cmd == CMD_WRITE) begin
            walk_d = 1'b0;
            if (32'(in_index) < STORE) begin
              mark_we    = 1'b1;
              mark_waddr = VW'(in_index);
              mark_wdata = in_mark;
            end
          end else if (start_walk) begin
            // The second root goes on the stack, the first is worked on at once.
            walk_d    = 1'b1;
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = {VW'(gdim - DW'(1)), VW'(0), VW'(gsq - SQW'(1)), LW'(0)};
            depth_d   = SDW'(1);
            a_d       = VW'(gsq - SQW'(gdim));
            b_d       = VW'(gsq - SQW'(1));
            c_d       = '0;
            lvl_d     = '0;
          end else begin
            depth_d = depth_q - SDW'(1);
          end
        end
      end
      ST_POP: begin
        {a_d, b_d, c_d, lvl_d} = stk_rd_q;
      end
      ST_EVAL: begin
      end
      ST_CHECK: begin
        if (mark_rd_q) begin
          if (32'(depth_q) < STACK) begin
            stk_we  = 1'b1;
            depth_d = depth_q + SDW'(1);
          end
          a_d   = mid;
          b_d   = a_q;
          c_d   = b_q;
          lvl_d = lvl_q + LW'(1);
        end
      end
      ST_EMIT: begin
        out_load = !out_valid_q || m_axis_tready;
        if (out_load && depth_q == '0) walk_d = 1'b0;
      end
      default: begin
      end
    endcase
    if (cfg_acc && (cfg_index_i == REG_VERT_DIM || cfg_index_i == REG_MAX_LEVEL)) begin
      walk_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd_q <= mark_mem[mid];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      vert_dim_q  <= VERT_DIM_RST;
      max_level_q <= MAX_LEVEL_RST;
      walk_q      <= 1'b0;
      depth_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      depth_q <= depth_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + VW'(1);
      if (cfg_acc) begin
        case (cfg_index_i)
          REG_VERT_DIM:  vert_dim_q  <= cfg_data_i[VERT_DIM_W-1:0];
          REG_MAX_LEVEL: max_level_q <= cfg_data_i[MAX_LEVEL_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    lvl_q <= lvl_d;
    if (out_load) begin
      out_a_q    <= IDX_W'(a_q);
      out_b_q    <= IDX_W'(b_q);
      out_c_q    <= IDX_W'(c_q);
      out_last_q <= (depth_q == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_c_q, out_b_q, out_a_q};
  assign m_axis_tlast  = out_last_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(depth_q) <= STACK)
    else $error("stack depth beyond its storage");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |-> lvl_q <= lim)
    else $error("node level above the level limit");

  a_write_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd == CMD_WRITE |=> state_q == ST_IDLE && !walk_q)
    else $error("mark write did not end the walk");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && depth_q == '0 |=> !walk_q && m_axis_tlast && m_axis_tvalid)
    else $error("final triangle did not close the walk");

endmodule
